[rtl/sprq_pkg.sv]
// Package: shared codes, state type and controller command struct for the ready queue.
package sprq_pkg;

    localparam int ModeW   = 2;
    localparam int PrioW   = 8;
    localparam int PidW    = 16;
    localparam int StatusW = 2;
    localparam int OccW    = 5;

    localparam logic [ModeW-1:0] MODE_PUSH   = 2'd0;
    localparam logic [ModeW-1:0] MODE_POP    = 2'd1;
    localparam logic [ModeW-1:0] MODE_REMOVE = 2'd2;

    localparam logic [StatusW-1:0] ST_OK       = 2'd0;
    localparam logic [StatusW-1:0] ST_FULL     = 2'd1;
    localparam logic [StatusW-1:0] ST_EMPTY    = 2'd2;
    localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_UPD
    } t_state;

    typedef struct packed {
        logic capture;
        logic compare;
        logic select;
        logic commit;
    } t_ctrl_cmd;

endpackage

[rtl/sprq_if.sv]
// Interfaces: request and result item channels of the ready queue.
interface sprq_req_if;
    logic                           valid;
    logic                           ready;
    logic [sprq_pkg::ModeW-1:0]     mode;
    logic [sprq_pkg::PrioW-1:0]     prio;
    logic [sprq_pkg::PidW-1:0]      pid;

    modport source (output valid, output mode, output prio, output pid, input ready);
    modport sink   (input valid, input mode, input prio, input pid, output ready);
endinterface

interface sprq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [sprq_pkg::StatusW-1:0]   status;
    logic [sprq_pkg::PidW-1:0]      popped_pid;
    logic                           head_valid;
    logic [sprq_pkg::PidW-1:0]      head_pid;
    logic [sprq_pkg::PrioW-1:0]     head_prio;
    logic [sprq_pkg::OccW-1:0]      occupancy;

    modport source (output valid, output status, output popped_pid, output head_valid,
                    output head_pid, output head_prio, output occupancy, input ready);
    modport sink   (input valid, input status, input popped_pid, input head_valid,
                    input head_pid, input head_prio, input occupancy, output ready);
endinterface

[rtl/sprq_ctrl.sv]
// Controller: sequences compare, select and commit for one item, owns both handshakes.
module sprq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sprq_pkg::t_ctrl_cmd o_cmd
);

    sprq_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             can_commit;

    assign can_commit = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sprq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sprq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sprq_pkg::S_CMP;
            end
            sprq_pkg::S_CMP: n_state = sprq_pkg::S_SEL;
            sprq_pkg::S_SEL: n_state = sprq_pkg::S_UPD;
            sprq_pkg::S_UPD: begin
                if (can_commit) n_state = sprq_pkg::S_IDLE;
            end
            default: n_state = sprq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            sprq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            sprq_pkg::S_CMP: o_cmd.compare = 1'b1;
            sprq_pkg::S_SEL: o_cmd.select  = 1'b1;
            sprq_pkg::S_UPD: o_cmd.commit  = can_commit;
            default: o_in_ready = 1'b0;
        endcase
    end

    // result register valid: set on commit, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit)               n_out_valid = 1'b1;
        else if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/sprq_dp.sv]
// Datapath: sorted slot array with per-slot compare, shift network and result registers.
module sprq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sprq_pkg::t_ctrl_cmd              i_cmd,
    input  logic [sprq_pkg::ModeW-1:0]       i_mode,
    input  logic [sprq_pkg::PrioW-1:0]       i_prio,
    input  logic [sprq_pkg::PidW-1:0]        i_pid,
    output logic [sprq_pkg::StatusW-1:0]     o_status,
    output logic [sprq_pkg::PidW-1:0]        o_popped_pid,
    output logic                             o_head_valid,
    output logic [sprq_pkg::PidW-1:0]        o_head_pid,
    output logic [sprq_pkg::PrioW-1:0]       o_head_prio,
    output logic [sprq_pkg::OccW-1:0]        o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [sprq_pkg::ModeW-1:0]  r_mode;
    logic [sprq_pkg::PrioW-1:0]  r_prio;
    logic [sprq_pkg::PidW-1:0]   r_pid;

    logic [sprq_pkg::PrioW-1:0]  r_slot_prio [DEPTH];
    logic [sprq_pkg::PidW-1:0]   r_slot_pid  [DEPTH];
    logic [sprq_pkg::PrioW-1:0]  n_slot_prio [DEPTH];
    logic [sprq_pkg::PidW-1:0]   n_slot_pid  [DEPTH];
    logic [CW-1:0]               r_count, n_count;

    logic [DEPTH-1:0]            r_le, r_match, r_ge;
    logic                        r_hit;
    logic [DEPTH-1:0]            n_le, n_match, sel_vec, below;

    logic [sprq_pkg::StatusW-1:0] n_status;
    logic [sprq_pkg::PidW-1:0]    n_popped;
    logic                         write_en;
    logic [CW+sprq_pkg::OccW-1:0] occ_ext;

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_prio <= i_prio;
            r_pid  <= i_pid;
        end
    end

    // per-slot compares, only slots below the count take part
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_le[i]    = (CW'(i) < r_count) && (r_slot_prio[i] <= r_prio);
            n_match[i] = (CW'(i) < r_count) && (r_slot_pid[i] == r_pid);
        end
    end

    // removal point: pop always takes slot 0, remove takes the first match
    assign sel_vec = (r_mode == sprq_pkg::MODE_POP) ? DEPTH'(r_count != '0) : r_match;
    assign below   = (sel_vec - DEPTH'(1)) & ~sel_vec;

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_le    <= n_le;
            r_match <= n_match;
        end
        if (i_cmd.select) begin
            r_ge  <= ~below;
            r_hit <= |sel_vec;
        end
    end

    // update: insert shifts up past the last slot with prio <= new, removal shifts down
    always_comb begin
        n_status = sprq_pkg::ST_OK;
        n_popped = '0;
        write_en = 1'b0;
        n_count  = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            n_slot_prio[i] = r_slot_prio[i];
            n_slot_pid[i]  = r_slot_pid[i];
        end
        case (r_mode) inside
            sprq_pkg::MODE_PUSH: begin
                if (r_count >= CW'(DEPTH)) begin
                    n_status = sprq_pkg::ST_FULL;
                end else begin
                    write_en = 1'b1;
                    n_count  = r_count + CW'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!r_le[i]) begin
                            if (i == 0 || r_le[(i == 0) ? 0 : i - 1]) begin
                                n_slot_prio[i] = r_prio;
                                n_slot_pid[i]  = r_pid;
                            end else begin
                                n_slot_prio[i] = r_slot_prio[(i == 0) ? 0 : i - 1];
                                n_slot_pid[i]  = r_slot_pid[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                end
            end
            sprq_pkg::MODE_POP, sprq_pkg::MODE_REMOVE: begin
                if (!r_hit) begin
                    n_status = (r_mode == sprq_pkg::MODE_POP) ? sprq_pkg::ST_EMPTY
                                                             : sprq_pkg::ST_NOTFOUND;
                end else begin
                    write_en = 1'b1;
                    n_count  = r_count - CW'(1);
                    if (r_mode == sprq_pkg::MODE_POP) n_popped = r_slot_pid[0];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (r_ge[i]) begin
                            n_slot_prio[i] = r_slot_prio[i + 1];
                            n_slot_pid[i]  = r_slot_pid[i + 1];
                        end
                    end
                end
            end
            default: n_status = sprq_pkg::ST_OK;  // undefined mode: no change
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && write_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_slot_prio[i] <= n_slot_prio[i];
                r_slot_pid[i]  <= n_slot_pid[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    assign occ_ext = {{sprq_pkg::OccW{1'b0}}, n_count};

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_status     <= n_status;
            o_popped_pid <= n_popped;
            o_head_valid <= (n_count != '0);
            o_head_pid   <= (n_count != '0) ? n_slot_pid[0]  : '0;
            o_head_prio  <= (n_count != '0) ? n_slot_prio[0] : '0;
            o_occupancy  <= occ_ext[sprq_pkg::OccW-1:0];
        end
    end

endmodule

[rtl/stable_priority_ready_queue_unit.sv]
// Top level: stable priority ready queue, controller plus slot-array datapath.
// Each item is captured, then walks compare, select and update; the commit in update
// writes the result register. A new item is taken only once the previous one has committed.
// A waiting result does not block the next item; commit stalls only while the result
// register is still full. Reset (i_rst_n low, synchronous) empties the queue, clears the
// result valid and returns the controller to idle; slot contents are not cleared.
module stable_priority_ready_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sprq_req_if.sink      i_req,
    sprq_rsp_if.source    o_rsp
);

    sprq_pkg::t_ctrl_cmd cmd;

    // Controller: owns ready/valid and the four-step item sequence.
    sprq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // Datapath: slots kept sorted by priority, ties in arrival order.
    // Insert point and first match come from per-slot compares in parallel.
    sprq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_req.mode),
        .i_prio       (i_req.prio),
        .i_pid        (i_req.pid),
        .o_status     (o_rsp.status),
        .o_popped_pid (o_rsp.popped_pid),
        .o_head_valid (o_rsp.head_valid),
        .o_head_pid   (o_rsp.head_pid),
        .o_head_prio  (o_rsp.head_prio),
        .o_occupancy  (o_rsp.occupancy)
    );

    // One item in flight: no new item taken right after an accept.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("item accepted while previous item in flight");

    // A dropped push only happens with a full queue.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == sprq_pkg::ST_FULL) |->
        (o_rsp.head_valid && o_rsp.occupancy == DEPTH[sprq_pkg::OccW-1:0]))
        else $error("full status with queue not full");

    // An empty pop leaves an empty queue with zeroed head fields.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == sprq_pkg::ST_EMPTY) |->
        (!o_rsp.head_valid && o_rsp.occupancy == '0 && o_rsp.popped_pid == '0))
        else $error("empty status with entries held");

    // Empty head reads as zero.
    a_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.head_valid) |->
        (o_rsp.head_pid == '0 && o_rsp.head_prio == '0))
        else $error("head fields nonzero on empty queue");

endmodule

[test/tb_top.sv]
// Testbench for the stable priority ready queue: shadow queue scoreboard and random traffic.
`timescale 1ns / 1ps

typedef struct packed {
    logic [sprq_pkg::StatusW-1:0] status;
    logic [sprq_pkg::PidW-1:0]    popped_pid;
    logic                         head_valid;
    logic [sprq_pkg::PidW-1:0]    head_pid;
    logic [sprq_pkg::PrioW-1:0]   head_prio;
    logic [sprq_pkg::OccW-1:0]    occupancy;
} t_queue_result;

// Shadow copy of the ready queue plus the list of results still owed by the block.
class t_ready_queue_scoreboard;
    int unsigned                depth;
    int unsigned                fill;
    logic [sprq_pkg::PrioW-1:0] held_prio[];
    logic [sprq_pkg::PidW-1:0]  held_pid[];
    t_queue_result              owed_results[$];
    int unsigned                errors;

    function new(int unsigned d);
        depth     = d;
        fill      = 0;
        errors    = 0;
        held_prio = new[d];
        held_pid  = new[d];
    endfunction

    function int unsigned pending();
        return owed_results.size();
    endfunction

    // Any held id, so removes mostly hit; a random id when the queue is empty.
    function logic [sprq_pkg::PidW-1:0] any_held_pid();
        if (fill == 0) return sprq_pkg::PidW'($urandom);
        return held_pid[$urandom_range(fill - 1)];
    endfunction

    function void close_slot(int unsigned at);
        for (int unsigned i = at; i + 1 < fill; i++) begin
            held_prio[i] = held_prio[i + 1];
            held_pid[i]  = held_pid[i + 1];
        end
        fill--;
    endfunction

    function void note_request(logic [sprq_pkg::ModeW-1:0] mode,
                               logic [sprq_pkg::PrioW-1:0] prio,
                               logic [sprq_pkg::PidW-1:0] pid);
        t_queue_result r;
        int unsigned   pos;
        r        = '0;
        r.status = sprq_pkg::ST_OK;
        case (mode)
            sprq_pkg::MODE_PUSH: begin
                if (fill >= depth) begin
                    r.status = sprq_pkg::ST_FULL;
                end else begin
                    // stable insert: after every entry of equal or better priority
                    pos = 0;
                    while (pos < fill && held_prio[pos] <= prio) pos++;
                    for (int unsigned i = fill; i > pos; i--) begin
                        held_prio[i] = held_prio[i - 1];
                        held_pid[i]  = held_pid[i - 1];
                    end
                    held_prio[pos] = prio;
                    held_pid[pos]  = pid;
                    fill++;
                end
            end
            sprq_pkg::MODE_POP: begin
                if (fill == 0) begin
                    r.status = sprq_pkg::ST_EMPTY;
                end else begin
                    r.popped_pid = held_pid[0];
                    close_slot(0);
                end
            end
            sprq_pkg::MODE_REMOVE: begin
                pos = 0;
                while (pos < fill && held_pid[pos] != pid) pos++;
                if (pos < fill) close_slot(pos);
                else            r.status = sprq_pkg::ST_NOTFOUND;
            end
            default: ;  // unused code: no change, ok status
        endcase
        if (fill != 0) begin
            r.head_valid = 1'b1;
            r.head_pid   = held_pid[0];
            r.head_prio  = held_prio[0];
        end
        r.occupancy = sprq_pkg::OccW'(fill);
        owed_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_queue_result got);
        t_queue_result want;
        if (owed_results.size() == 0) begin
            $error("result item with no request outstanding");
            errors++;
            return;
        end
        want = owed_results.pop_front();
        compare_field("status",     want.status,     got.status);
        compare_field("popped_pid", want.popped_pid, got.popped_pid);
        compare_field("head_valid", want.head_valid, got.head_valid);
        compare_field("head_pid",   want.head_pid,   got.head_pid);
        compare_field("head_prio",  want.head_prio,  got.head_prio);
        compare_field("occupancy",  want.occupancy,  got.occupancy);
    endfunction
endclass

module tb_top;

    localparam int                          QDEPTH       = 16;
    localparam logic [sprq_pkg::ModeW-1:0] MODE_UNUSED  = 2'd3;
    localparam int                          LIMIT_CYCLES = 400000;
    localparam int                          HOLD_CYCLES  = 300;
    localparam int                          BLOCKS       = 17;
    localparam int                          BLOCK_ITEMS  = 100;

    logic i_clk;
    logic i_rst_n;

    sprq_req_if req_ch ();
    sprq_rsp_if rsp_ch ();

    stable_priority_ready_queue_unit #(.DEPTH(QDEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_ready_queue_scoreboard sb;

    int            idle_pct;        // sender gap odds, percent per cycle
    int            stall_pct;       // receiver stall odds, percent per cycle
    int            hold_requests;   // bumped by the stimulus to ask for a long stall
    int            hold_served;
    int            hold_left;
    int unsigned   cycle_count;
    t_queue_result seen;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit, well above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Both channels sampled at the edge, before any update scheduled at it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.mode, req_ch.prio, req_ch.pid);
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.status     = rsp_ch.status;
                seen.popped_pid = rsp_ch.popped_pid;
                seen.head_valid = rsp_ch.head_valid;
                seen.head_pid   = rsp_ch.head_pid;
                seen.head_prio  = rsp_ch.head_prio;
                seen.occupancy  = rsp_ch.occupancy;
                sb.check_result(seen);
            end
        end
    end

    task automatic send_item(logic [sprq_pkg::ModeW-1:0] mode,
                             logic [sprq_pkg::PrioW-1:0] prio,
                             logic [sprq_pkg::PidW-1:0] pid);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.prio  <= prio;
        req_ch.pid   <= pid;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Mix of operations in percent; whatever is left over goes to the unused code.
    task automatic send_random_item(int push_pct, int pop_pct, int remove_pct);
        int                         pick;
        logic [sprq_pkg::PrioW-1:0] prio;
        logic [sprq_pkg::PidW-1:0]  pid;
        pick = $urandom_range(99);
        prio = ($urandom_range(1) == 0) ? sprq_pkg::PrioW'($urandom_range(7))
                                        : sprq_pkg::PrioW'($urandom);
        pid  = ($urandom_range(1) == 0) ? sprq_pkg::PidW'($urandom_range(15))
                                        : sprq_pkg::PidW'($urandom);
        if (pick < push_pct) begin
            send_item(sprq_pkg::MODE_PUSH, prio, pid);
        end else if (pick < push_pct + pop_pct) begin
            send_item(sprq_pkg::MODE_POP, prio, pid);
        end else if (pick < push_pct + pop_pct + remove_pct) begin
            if ($urandom_range(3) != 0) pid = sb.any_held_pid();
            send_item(sprq_pkg::MODE_REMOVE, prio, pid);
        end else begin
            send_item(MODE_UNUSED, prio, pid);
        end
    endtask

    // One edge first, so the item accepted at the current edge is already noted.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic set_idling(int phase);
        case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    initial begin
        sb            = new(QDEPTH);
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        hold_served   = 0;
        hold_left     = 0;
        cycle_count   = 0;
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.mode   = sprq_pkg::MODE_PUSH;
        req_ch.prio   = '0;
        req_ch.pid    = '0;
        rsp_ch.ready  = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-queue cases, field extremes, equal priorities, removes.
        send_item(sprq_pkg::MODE_POP,    8'h00, 16'h0000);   // pop of an empty queue
        send_item(sprq_pkg::MODE_REMOVE, 8'h00, 16'h0000);   // remove from an empty queue
        send_item(MODE_UNUSED,           8'hFF, 16'hFFFF);   // unused code while empty
        send_item(sprq_pkg::MODE_PUSH,   8'hFF, 16'hFFFF);
        send_item(sprq_pkg::MODE_PUSH,   8'h00, 16'h0000);
        send_item(sprq_pkg::MODE_PUSH,   8'h80, 16'h1234);
        send_item(sprq_pkg::MODE_PUSH,   8'h80, 16'h5678);   // same priority keeps order
        send_item(sprq_pkg::MODE_PUSH,   8'h80, 16'hAAAA);
        send_item(sprq_pkg::MODE_PUSH,   8'h80, 16'h1234);   // duplicate id: first match goes
        send_item(sprq_pkg::MODE_REMOVE, 8'h00, 16'h5678);   // hit in the middle
        send_item(sprq_pkg::MODE_REMOVE, 8'h00, 16'h9999);   // miss
        send_item(sprq_pkg::MODE_REMOVE, 8'h00, 16'h1234);
        send_item(MODE_UNUSED,           8'h55, 16'h5555);   // unused code with entries held
        send_item(sprq_pkg::MODE_REMOVE, 8'h00, 16'hFFFF);   // tail entry
        send_item(sprq_pkg::MODE_POP,    8'h00, 16'h0000);
        send_item(sprq_pkg::MODE_POP,    8'h00, 16'h0000);
        send_item(sprq_pkg::MODE_POP,    8'h00, 16'h0000);
        send_item(sprq_pkg::MODE_POP,    8'h00, 16'h0000);   // pop once the queue is empty again
        wait_drained();

        // Random: blocks that cycle through idling phases and fill, drain, mixed traffic.
        for (int b = 0; b < BLOCKS; b++) begin
            set_idling(b % 4);
            if (b == 5) begin
                // long receiver hold while the sender keeps going: block backs up
                idle_pct = 0;
                hold_requests++;
            end
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                case (b % 3)
                    0:       send_random_item(75, 10, 12);
                    1:       send_random_item(15, 65, 17);
                    default: send_random_item(45, 35, 17);
                endcase
            end
            if (b % 4 == 3) wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
